FILE: hdl/wcsf_pkg.sv
// Package for the WebAssembly custom section finder: widths, codes and header bytes.
`default_nettype none

package wcsf_pkg;

  localparam int unsigned MaxNameBytes = 16;
  localparam int unsigned MaxLebBytes  = 5;

  localparam int unsigned ModLenW   = 32;
  localparam int unsigned NameLenW  = 5;
  localparam int unsigned NameWordW = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned OutDataW  = 72;

  localparam logic [31:0] ModLenReset = 32'd8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgModuleLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNameLength   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNameLow      = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNameHigh     = 2'd3;

  // result status codes
  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StInvalid  = 2'd1;
  localparam logic [1:0] StTrunc    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  localparam logic [7:0] LebDataMask = 8'h7F;

  // magic "\0asm" then version 1
  function automatic logic [7:0] wasm_header_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h00;
      3'd1:    val = 8'h61;
      3'd2:    val = 8'h73;
      3'd3:    val = 8'h6d;
      3'd4:    val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/wasm_custom_section_finder.sv
// Top level: byte-serial WebAssembly section walker that locates one custom section.
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata[7:0] module_byte
// m_axis    out        tdata[1:0] status, [33:2] data_offset, [65:34] data_length, [71:66] zero
// cfg       in         cfg_index_i register index, cfg_data_i value (low bits used)
//
// One byte per cycle while s_axis_tready_o is high: each accepted byte is parsed in a
// single pass into the parser state registers, and a result lands in the output register
// on the same edge; that register drives m_axis_tvalid_o directly.
// s_axis_tready_o drops only while a result is held and m_axis_tready_i is low.
// Asynchronous active-low reset puts the parser at the start of a module header.
module wasm_custom_section_finder
  import wcsf_pkg::*;
#(
  parameter int unsigned MAX_NAME_BYTES = MaxNameBytes
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // module bytes in: tdata = module_byte
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  input  wire logic [7:0]            s_axis_tdata_i,
  // results out: tdata = status, data_offset, data_length, zero fill
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output      logic [OutDataW-1:0]   m_axis_tdata_o,
  // register writes
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i
);

  // parse phases
  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhId      = 3'd1;
  localparam logic [2:0] PhPayLen  = 3'd2;
  localparam logic [2:0] PhNameLen = 3'd3;
  localparam logic [2:0] PhName    = 3'd4;
  localparam logic [2:0] PhSkip    = 3'd5;
  localparam logic [2:0] PhDone    = 3'd6;

  // configuration
  logic [ModLenW-1:0]   mlen_q;
  logic [NameLenW-1:0]  tlen_q;
  logic [NameWordW-1:0] tlow_q, thigh_q;

  // parser state
  logic [31:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        custom_q, custom_d;
  logic [32:0] send_q, send_d;
  logic [31:0] nrem_q, nrem_d;
  logic [4:0]  nidx_q, nidx_d;
  logic        mism_q, mism_d;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_off_q, out_len_q;

  logic        in_fire, cfg_fire;
  logic [7:0]  b;
  logic [32:0] next_pos;
  logic [31:0] leb_part, acc_new;
  logic [33:0] len_sum;
  logic [2:0]  cnt_inc;
  logic [7:0]  name_bytes [16];
  logic [7:0]  wanted;
  logic [31:0] nrem_dec;
  logic        name_fin, mod_end;
  logic        res_valid;
  logic [1:0]  res_status;
  logic [31:0] res_off, res_len;
  logic [32:0] found_len;

  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_len_q, out_off_q, out_status_q};

  assign b        = s_axis_tdata_i;
  assign next_pos = {1'b0, pos_q} + 33'd1;
  assign cnt_inc  = cnt_q + 3'd1;
  assign nrem_dec = nrem_q - 32'd1;

  // LEB128 group placed at 7 * byte count; bits past 32 fall off
  always_comb begin
    unique case (cnt_q)
      3'd0:    leb_part = {25'd0, b[6:0]};
      3'd1:    leb_part = {18'd0, b[6:0], 7'd0};
      3'd2:    leb_part = {11'd0, b[6:0], 14'd0};
      3'd3:    leb_part = {4'd0, b[6:0], 21'd0};
      3'd4:    leb_part = {b[3:0], 28'd0};
      default: leb_part = 32'd0;
    endcase
  end

  assign acc_new = acc_q | (leb_part & {25'd0, LebDataMask[6:0]} << 0 | leb_part);
  assign len_sum = {1'b0, next_pos} + {2'd0, acc_new};

  for (genvar gi = 0; gi < 8; gi++) begin : g_name
    assign name_bytes[gi]     = tlow_q[8*gi +: 8];
    assign name_bytes[gi + 8] = thigh_q[8*gi +: 8];
  end
  assign wanted    = name_bytes[nidx_q[3:0]];
  assign found_len = send_q - next_pos;

  always_comb begin
    pos_d      = pos_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    custom_d   = custom_q;
    send_d     = send_q;
    nrem_d     = nrem_q;
    nidx_d     = nidx_q;
    mism_d     = mism_q;
    name_fin   = 1'b0;
    res_valid  = 1'b0;
    res_status = StInvalid;
    res_off    = 32'd0;
    res_len    = 32'd0;

    unique case (phase_q)
      PhHeader: begin
        if (mlen_q < ModLenReset || b != wasm_header_byte(pos_q[2:0])) begin
          res_valid  = 1'b1;
          res_status = StInvalid;
          phase_d    = PhDone;
        end else if (pos_q >= 32'd7) begin
          phase_d = PhId;
        end
      end
      PhId: begin
        custom_d = (b == 8'd0);
        acc_d    = 32'd0;
        cnt_d    = 3'd0;
        phase_d  = PhPayLen;
      end
      PhPayLen: begin
        acc_d = acc_new;
        if (b[7]) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= 3'(MaxLebBytes)) begin
            res_valid  = 1'b1;
            res_status = StTrunc;
            phase_d    = PhDone;
          end
        end else if (len_sum > {2'd0, mlen_q}) begin
          res_valid  = 1'b1;
          res_status = StTrunc;
          phase_d    = PhDone;
        end else begin
          send_d = len_sum[32:0];
          if (custom_q) begin
            if (acc_new == 32'd0) begin
              // empty custom payload cannot hold a name length
              res_valid  = 1'b1;
              res_status = StTrunc;
              phase_d    = PhDone;
            end else begin
              acc_d   = 32'd0;
              cnt_d   = 3'd0;
              phase_d = PhNameLen;
            end
          end else begin
            phase_d = (acc_new == 32'd0) ? PhId : PhSkip;
          end
        end
      end
      PhNameLen: begin
        acc_d = acc_new;
        if (b[7]) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= 3'(MaxLebBytes) || next_pos >= send_q) begin
            res_valid  = 1'b1;
            res_status = StTrunc;
            phase_d    = PhDone;
          end
        end else if (len_sum > {1'b0, send_q}) begin
          res_valid  = 1'b1;
          res_status = StTrunc;
          phase_d    = PhDone;
        end else begin
          nrem_d = acc_new;
          nidx_d = 5'd0;
          mism_d = (acc_new != {27'd0, tlen_q}) ||
                   ({27'd0, tlen_q} > 32'(MAX_NAME_BYTES));
          if (acc_new == 32'd0) name_fin = 1'b1;
          else                  phase_d = PhName;
        end
      end
      PhName: begin
        if ({27'd0, nidx_q} < 32'(MAX_NAME_BYTES)) begin
          if (b != wanted) mism_d = 1'b1;
          nidx_d = nidx_q + 5'd1;
        end else begin
          mism_d = 1'b1;
        end
        nrem_d = nrem_dec;
        if (nrem_dec == 32'd0) name_fin = 1'b1;
      end
      PhSkip: begin
        if (next_pos >= send_q) phase_d = PhId;
      end
      default: ;
    endcase

    // name complete: report on a match, else carry on walking sections
    if (name_fin) begin
      if (!mism_d) begin
        res_valid  = 1'b1;
        res_status = StFound;
        res_off    = next_pos[31:0];
        res_len    = found_len[31:0];
        phase_d    = PhDone;
      end else begin
        phase_d = (next_pos >= send_q) ? PhId : PhSkip;
      end
    end

    pos_d = next_pos[31:0];

    // module end: give the pending verdict, then start afresh
    if (mod_end) begin
      if (phase_d != PhDone) begin
        res_valid = 1'b1;
        res_off   = 32'd0;
        res_len   = 32'd0;
        if (phase_d == PhHeader)                        res_status = StInvalid;
        else if (phase_d == PhId || phase_d == PhSkip) res_status = StNotFound;
        else                                            res_status = StTrunc;
      end
      pos_d    = 32'd0;
      phase_d  = PhHeader;
      acc_d    = 32'd0;
      cnt_d    = 3'd0;
      custom_d = 1'b0;
      send_d   = 33'd0;
      nrem_d   = 32'd0;
      nidx_d   = 5'd0;
      mism_d   = 1'b0;
    end
  end

  assign mod_end = (next_pos >= {1'b0, mlen_q}) || next_pos[32];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mlen_q  <= ModLenReset;
      tlen_q  <= '0;
      tlow_q  <= '0;
      thigh_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CfgModuleLength: mlen_q  <= cfg_data_i[ModLenW-1:0];
        CfgNameLength:   tlen_q  <= cfg_data_i[NameLenW-1:0];
        CfgNameLow:      tlow_q  <= cfg_data_i;
        CfgNameHigh:     thigh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser state, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PhHeader;
      acc_q    <= '0;
      cnt_q    <= '0;
      custom_q <= 1'b0;
      send_q   <= '0;
      nrem_q   <= '0;
      nidx_q   <= '0;
      mism_q   <= 1'b0;
    end else if (in_fire) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      custom_q <= custom_d;
      send_q   <= send_d;
      nrem_q   <= nrem_d;
      nidx_q   <= nidx_d;
      mism_q   <= mism_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_status_q <= res_status;
      out_off_q    <= res_off;
      out_len_q    <= res_len;
    end
  end

endmodule

`default_nettype wire

FILE: bench/wasm_custom_section_finder_tb.sv
// Testbench for the WebAssembly custom section finder: directed rows, then random modules.
module wasm_custom_section_finder_tb
  import wcsf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // "\0asm" followed by version 1, byte 0 in the lowest bits
  localparam logic [63:0] WasmPreamble = 64'h0000_0001_6d73_6100;
  localparam int unsigned RandomBytes = 1250;

  // Result as it travels on m_axis tdata: status lowest, then offset, then length.
  typedef struct packed {
    logic [31:0] length;
    logic [31:0] offset;
    logic [1:0]  status;
  } section_report_t;

  // One row of the directed table: either a register write or a module byte.
  // A byte row may carry a hand-typed status (offset and length then zero).
  typedef struct packed {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    bit          typed;
    logic [1:0]  typed_status;
  } plan_row_t;

  typedef enum logic [3:0] {
    WalkHeader, WalkId, WalkPayLen, WalkNameLen, WalkName, WalkSkip, WalkDone
  } walk_phase_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;   // [7:0] module_byte
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;   // [1:0] status, [33:2] offset, [65:34] length, rest zero
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wasm_custom_section_finder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the parser: register file and walker state.
  // ---------------------------------------------------------------------------
  logic [31:0] mod_len;
  logic [4:0]  want_len;
  logic [63:0] want_lo;
  logic [63:0] want_hi;

  logic [31:0] byte_pos;
  walk_phase_e walk_phase;
  logic [31:0] leb_value;
  logic [2:0]  leb_count;
  bit          in_custom;
  logic [32:0] section_stop;
  logic [31:0] name_left;
  logic [4:0]  name_at;
  bit          name_differs;
  bit          report_done;

  bit              scan_hit;     // the last scanned byte produced a result
  section_report_t scan_report;

  section_report_t pending_reports[$];
  logic [7:0]      mod_bytes[$];
  plan_row_t       plan[$];
  int unsigned     fault_count;
  bit              quiet_mode;   // no source gaps for the current module

  function automatic logic [7:0] wanted_byte(input logic [4:0] idx);
    if (idx < 5'd8) return want_lo[8*idx[2:0] +: 8];
    return want_hi[8*idx[2:0] +: 8];
  endfunction

  task automatic walk_restart();
    byte_pos     = '0;
    walk_phase   = WalkHeader;
    leb_value    = '0;
    leb_count    = '0;
    in_custom    = 1'b0;
    section_stop = '0;
    name_left    = '0;
    name_at      = '0;
    name_differs = 1'b0;
    report_done  = 1'b0;
  endtask

  task automatic settle(input logic [1:0] st, input logic [31:0] off, input logic [31:0] len);
    scan_hit           = 1'b1;
    scan_report.status = st;
    scan_report.offset = off;
    scan_report.length = len;
    report_done        = 1'b1;
    walk_phase         = WalkDone;
  endtask

  // 7 data bits per LEB byte; anything shifted past bit 31 falls off
  task automatic leb_take(input logic [7:0] b);
    int          shift;
    logic [31:0] part;
    shift = 7 * leb_count;
    part  = {25'b0, b[6:0]};
    if (shift < 32) leb_value = leb_value | (part << shift);
  endtask

  task automatic name_complete(input logic [32:0] nxt);
    logic [32:0] rest;
    rest = section_stop - nxt;
    if (!name_differs) settle(StFound, nxt[31:0], rest[31:0]);
    else walk_phase = (nxt >= section_stop) ? WalkId : WalkSkip;
  endtask

  // Advance the shadow parser by one accepted module byte.
  task automatic scan_byte(input logic [7:0] b);
    logic [32:0] nxt;
    logic [33:0] reach;
    logic [1:0]  st;
    scan_hit    = 1'b0;
    scan_report = '0;
    nxt         = {1'b0, byte_pos} + 33'd1;
    reach       = {1'b0, nxt} + {2'b0, leb_value};
    case (walk_phase)
      WalkHeader: begin
        if (mod_len < 32'd8 || b != WasmPreamble[8*byte_pos[2:0] +: 8]) begin
          settle(StInvalid, '0, '0);
        end else if (byte_pos >= 32'd7) begin
          walk_phase = WalkId;
        end
      end
      WalkId: begin
        in_custom  = (b == 8'h00);
        leb_value  = '0;
        leb_count  = '0;
        walk_phase = WalkPayLen;
      end
      WalkPayLen: begin
        leb_take(b);
        reach = {1'b0, nxt} + {2'b0, leb_value};
        if (b[7]) begin
          leb_count = leb_count + 3'd1;
          if (leb_count >= MaxLebBytes) settle(StTrunc, '0, '0);
        end else if (reach > {2'b0, mod_len}) begin
          settle(StTrunc, '0, '0);
        end else begin
          section_stop = reach[32:0];
          if (in_custom) begin
            if (leb_value == '0) begin
              // custom section with no room for even a name length
              settle(StTrunc, '0, '0);
            end else begin
              leb_value  = '0;
              leb_count  = '0;
              walk_phase = WalkNameLen;
            end
          end else begin
            walk_phase = (leb_value == '0) ? WalkId : WalkSkip;
          end
        end
      end
      WalkNameLen: begin
        leb_take(b);
        reach = {1'b0, nxt} + {2'b0, leb_value};
        if (b[7]) begin
          leb_count = leb_count + 3'd1;
          if (leb_count >= MaxLebBytes || nxt >= section_stop) settle(StTrunc, '0, '0);
        end else if (reach > {1'b0, section_stop}) begin
          settle(StTrunc, '0, '0);
        end else begin
          name_left    = leb_value;
          name_at      = '0;
          name_differs = (leb_value != {27'b0, want_len}) || (want_len > MaxNameBytes);
          if (name_left == '0) name_complete(nxt);
          else walk_phase = WalkName;
        end
      end
      WalkName: begin
        if (name_at < MaxNameBytes) begin
          if (b != wanted_byte(name_at)) name_differs = 1'b1;
          name_at = name_at + 5'd1;
        end else begin
          name_differs = 1'b1;
        end
        name_left = name_left - 32'd1;
        if (name_left == '0) name_complete(nxt);
      end
      WalkSkip: begin
        if (nxt >= section_stop) walk_phase = WalkId;
      end
      default: ;
    endcase
    byte_pos = nxt[31:0];
    // module boundary: whatever is still open decides the status
    if (nxt >= {1'b0, mod_len} || nxt[32]) begin
      if (!report_done) begin
        if (walk_phase == WalkHeader) st = StInvalid;
        else if (walk_phase == WalkId || walk_phase == WalkSkip) st = StNotFound;
        else st = StTrunc;
        settle(st, '0, '0);
      end
      walk_restart();
    end
  endtask

  task automatic shadow_write(input logic [1:0] idx, input logic [63:0] v);
    case (idx)
      CfgModuleLength: mod_len  = v[31:0];
      CfgNameLength:   want_len = v[4:0];
      CfgNameLow:      want_lo  = v;
      CfgNameHigh:     want_hi  = v;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [63:0] v);
    plan_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.value   = v;
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] b);
    plan_row_t r;
    r = '0;
    r.value = {56'b0, b};
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [7:0] b, input logic [1:0] st);
    plan_row_t r;
    r = byte_row(b);
    r.typed        = 1'b1;
    r.typed_status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Module builder helpers
  // ---------------------------------------------------------------------------
  function automatic int leb_size(input logic [31:0] v);
    int n;
    n = 1;
    while (v >= 32'd128 && n < 5) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  // minimal encoding mostly, now and then padded with redundant continuation bytes
  function automatic int pick_leb_size(input logic [31:0] v);
    int n;
    n = leb_size(v);
    if ($urandom_range(0, 7) == 0) n = $urandom_range(n, 5);
    return n;
  endfunction

  task automatic add_leb(input logic [31:0] v, input int nb);
    logic [7:0] b;
    for (int i = 0; i < nb; i++) begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (i < nb - 1) b[7] = 1'b1;
      else if (i == 4) b[6:4] = 3'($urandom_range(0, 7));  // bits past 32, dropped
      mod_bytes.push_back(b);
    end
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) mod_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // A mostly well-formed module: header, a few sections, some custom ones that
  // carry the wanted name, plus the odd broken length, cut or overrun.
  task automatic build_module();
    int          nsec;
    int          dlen;
    int          nlen;
    int          nlb;
    int          kind;
    int          flip;
    int          cut;
    bit          rand_name;
    logic [31:0] pay;
    logic [7:0]  b;
    mod_bytes.delete();
    for (int i = 0; i < 8; i++) mod_bytes.push_back(WasmPreamble[8*i +: 8]);
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(0, 7);
      mod_bytes[cut] = mod_bytes[cut] ^ (8'h01 << $urandom_range(0, 7));
    end
    nsec = $urandom_range(0, 4);
    for (int s = 0; s < nsec; s++) begin
      dlen = $urandom_range(0, 6);
      kind = $urandom_range(0, 31);
      if ($urandom_range(0, 1) == 1) begin
        mod_bytes.push_back(8'($urandom_range(1, 255)));
        if (kind == 0) begin
          // five continued LEB bytes
          for (int i = 0; i < 5; i++) mod_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
        end else if (kind == 1) begin
          pay = $urandom;
          add_leb(pay, pick_leb_size(pay));
        end else begin
          add_leb(dlen, pick_leb_size(dlen));
          add_random(dlen);
        end
      end else begin
        rand_name = ($urandom_range(0, 2) == 0);
        nlen = rand_name ? $urandom_range(0, 20) : int'(want_len);
        flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nlen) : -1;
        nlb  = pick_leb_size(nlen);
        pay  = nlb + nlen + dlen;
        if (kind == 0) pay = 0;
        else if (kind <= 2) pay = $urandom_range(0, nlb + nlen - 1);
        else if (kind == 3) pay = nlb + nlen;
        mod_bytes.push_back(8'h00);
        add_leb(pay, pick_leb_size(pay));
        add_leb(nlen, nlb);
        for (int i = 0; i < nlen; i++) begin
          if (rand_name) b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
          else if (i < MaxNameBytes) b = wanted_byte(5'(i));
          else b = 8'($urandom_range(0, 255));
          if (i == flip) b = b ^ (8'h01 << $urandom_range(0, 7));
          mod_bytes.push_back(b);
        end
        add_random(dlen);
      end
    end
    case ($urandom_range(0, 7))
      0: begin
        // module ends somewhere inside what was built
        cut = mod_bytes.size() - $urandom_range(1, 6);
        while (mod_bytes.size() > cut) void'(mod_bytes.pop_back());
      end
      1: add_random($urandom_range(1, 6));
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------
  // Drain: stop sending, wait for every report, then allow for the output
  // register before the register file may be touched.
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_write(idx, v);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= {$urandom, $urandom};
  endtask

  // Offer one module byte and predict on acceptance. A typed status, when given,
  // takes the place of the predicted report.
  task automatic push_byte(input logic [7:0] b, input bit typed, input logic [1:0] st);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    scan_byte(b);
    if (typed) pending_reports.push_back('{length: '0, offset: '0, status: st});
    else if (scan_hit) pending_reports.push_back(scan_report);
    gap = 0;
    if (!quiet_mode) begin
      case ($urandom_range(0, 99)) inside
        [0:54]:  gap = 0;
        [55:91]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(8, 24);
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_name_regs();
    logic [4:0]  nl;
    logic [63:0] lo;
    logic [63:0] hi;
    case ($urandom_range(0, 9))
      0:       nl = 5'($urandom_range(17, 31));  // longer than the matcher holds
      1:       nl = 5'd16;
      2:       nl = 5'd0;
      default: nl = 5'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 5))
      0:       begin lo = '1; hi = '1; end
      1:       begin lo = '0; hi = '0; end
      default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
    endcase
    write_reg(CfgNameLength, {59'b0, nl});
    write_reg(CfgNameLow, lo);
    write_reg(CfgNameHigh, hi);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("wasm_custom_section_finder regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, short stalls mostly, a few long ones,
  // and now and then a long stretch of continuous ready.
  // ---------------------------------------------------------------------------
  initial begin
    int run;
    int stall;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      m_axis_tready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      case ($urandom_range(0, 99)) inside
        [0:39]:  stall = 0;
        [40:89]: stall = $urandom_range(1, 3);
        default: stall = $urandom_range(10, 30);
      endcase
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each output transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    section_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: tdata %h", m_axis_tdata_o);
        fault_count++;
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tdata_o[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata_o[1:0]);
          fault_count++;
        end
        if (m_axis_tdata_o[33:2] !== want.offset) begin
          $error("data_offset: expected %0d, got %0d", want.offset, m_axis_tdata_o[33:2]);
          fault_count++;
        end
        if (m_axis_tdata_o[65:34] !== want.length) begin
          $error("data_length: expected %0d, got %0d", want.length, m_axis_tdata_o[65:34]);
          fault_count++;
        end
        if (m_axis_tdata_o[OutDataW-1:66] !== '0) begin
          $error("zero fill: expected 0, got %h", m_axis_tdata_o[OutDataW-1:66]);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          fed;
    int          n;
    logic [31:0] ml;
    plan_row_t   row;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    fault_count     = 0;
    quiet_mode      = 1'b0;
    mod_len         = ModLenReset;
    want_len        = '0;
    want_lo         = '0;
    want_hi         = '0;
    walk_restart();

    // Directed table.
    // Short module: below 8 bytes every module is invalid on its first byte.
    plan.push_back(reg_row(CfgModuleLength, 64'd0));
    plan.push_back(typed_row(8'hFF, StInvalid));
    plan.push_back(typed_row(8'h00, StInvalid));
    // Header only: 8 good bytes and nothing else.
    plan.push_back(reg_row(CfgModuleLength, 64'd8));
    for (int i = 0; i < 7; i++) plan.push_back(byte_row(WasmPreamble[8*i +: 8]));
    plan.push_back(typed_row(8'h00, StNotFound));
    // Bad magic on the third byte of a maximum-length module ...
    plan.push_back(reg_row(CfgModuleLength, 64'hFFFF_FFFF));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h61));
    plan.push_back(typed_row(8'h74, StInvalid));
    // ... then the length drops below the bytes taken: the next byte closes it.
    plan.push_back(reg_row(CfgModuleLength, 64'd1));
    plan.push_back(byte_row(8'h55));
    // Found: empty id-1 section, then custom section named {00, 61}.
    plan.push_back(reg_row(CfgModuleLength, 64'd40));
    plan.push_back(reg_row(CfgNameLength, 64'd2));
    plan.push_back(reg_row(CfgNameLow, 64'h0000_0000_0000_6100));
    plan.push_back(reg_row(CfgNameHigh, 64'hFFFF_FFFF_FFFF_FFFF));
    for (int i = 0; i < 8; i++) plan.push_back(byte_row(WasmPreamble[8*i +: 8]));
    plan.push_back(byte_row(8'h01));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h85));  // padded LEB: payload 5
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h02));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h61));
    plan.push_back(reg_row(CfgModuleLength, 64'd1));
    plan.push_back(byte_row(8'hAA));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        quiesce();
        write_reg(row.reg_idx, row.value);
      end else begin
        push_byte(row.value[7:0], row.typed, row.typed_status);
      end
    end

    // Random modules. Each gets exactly module_length bytes (one byte if that is zero)
    // so that the register file is only rewritten on a module boundary.
    fed = 0;
    while (fed < RandomBytes) begin
      quiesce();
      quiet_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_name_regs();
      if ($urandom_range(0, 9) == 0) begin
        // noise: short or junk modules, header prefix now and then
        ml = $urandom_range(0, 12);
        n  = (ml == 0) ? 1 : int'(ml);
        mod_bytes.delete();
        add_random(n);
        if ($urandom_range(0, 1) == 1) begin
          for (int i = 0; i < n && i < 8; i++) mod_bytes[i] = WasmPreamble[8*i +: 8];
        end
      end else begin
        build_module();
        ml = mod_bytes.size();
      end
      write_reg(CfgModuleLength, {32'b0, ml});
      foreach (mod_bytes[i]) begin
        push_byte(mod_bytes[i], 1'b0, StFound);
        fed++;
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("wasm_custom_section_finder regression: pass");
    end else begin
      $display("wasm_custom_section_finder regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/wcsf_pkg.sv
hdl/wasm_custom_section_finder.sv
bench/wasm_custom_section_finder_tb.sv
